[hdl/psgd_pkg.sv]
`timescale 1ns / 1ps

package psgd_pkg;

   // Depth of the sample history ring and the width of its pointer.
   localparam int RING_DEPTH = 4;
   localparam int PTR_W      = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;

   // Widths of the payload and configuration fields.
   localparam int PROX_W   = 8;
   localparam int TIME_W   = 32;
   localparam int HOLD_W   = 16;
   localparam int COLOR_W  = 24;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 16;

   // Configuration register indexes.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PRESENCE_THRESHOLD = 3'd0,
      CSR_SETTLE_TIME_MS     = 3'd1,
      CSR_SWIPE_DELTA        = 3'd2,
      CSR_SWIPE_HOLD_MS      = 3'd3,
      CSR_BRIGHTNESS_SCALE   = 3'd4
   } csr_index_type;

   // Reset values of the configuration registers.
   localparam logic [PROX_W-1:0] RST_PRESENCE_THRESHOLD = 8'd10;
   localparam logic [HOLD_W-1:0] RST_SETTLE_TIME_MS     = 16'd100;
   localparam logic [PROX_W-1:0] RST_SWIPE_DELTA        = 8'd60;
   localparam logic [HOLD_W-1:0] RST_SWIPE_HOLD_MS      = 16'd200;
   localparam logic [PROX_W-1:0] RST_BRIGHTNESS_SCALE   = 8'd20;

   // Gesture states.
   typedef enum logic [1:0] {
      ST_IDLE    = 2'd0,
      ST_HAND    = 2'd1,
      ST_TOWARDS = 2'd2,
      ST_AWAY    = 2'd3
   } gesture_state_type;

   // LED colors shown for each state.
   localparam logic [COLOR_W-1:0] COLOR_IDLE    = 24'h000000;
   localparam logic [COLOR_W-1:0] COLOR_HAND    = 24'h800080;
   localparam logic [COLOR_W-1:0] COLOR_TOWARDS = 24'hFF8000;
   localparam logic [COLOR_W-1:0] COLOR_AWAY    = 24'h00FF00;

   // Color lookup for a state.
   function automatic logic [COLOR_W-1:0] color_of_state(input gesture_state_type st);
      logic [COLOR_W-1:0] color;
      unique case (st)
         ST_IDLE:    color = COLOR_IDLE;
         ST_HAND:    color = COLOR_HAND;
         ST_TOWARDS: color = COLOR_TOWARDS;
         ST_AWAY:    color = COLOR_AWAY;
         default:    color = COLOR_IDLE;
      endcase
      return color;
   endfunction

endpackage

[hdl/proximity_swipe_gesture_detector_core.sv]
`timescale 1ns / 1ps

// Proximity swipe gesture detector. Each request beat carries one 8-bit proximity
// sample and a millisecond timestamp; each one yields exactly one response beat with
// the new gesture state, a change flag, the LED color of the state held before that
// sample and a brightness scaled from that sample. A beat is held in the input
// register, then the state update and the 8x8 brightness product are formed
// combinationally and land in the response register; throughput is one beat per
// cycle while the response side keeps up.
// Configuration writes are always accepted (csr_ready is tied high); indexes above 4
// are ignored, and registers should only be written while no beat is in flight.
// Elapsed time wraps modulo 2^32, so a timestamp that runs backwards reads as a long
// wait. The sample ring starts at zeros after reset, and those zeros take part in the
// first swipe comparisons.
module proximity_swipe_gesture_detector_core (
   input  logic                              clock,
   input  logic                              reset,
   // Request channel
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [psgd_pkg::PROX_W-1:0]       req_proximity,
   input  logic [psgd_pkg::TIME_W-1:0]       req_now_ms,
   // Response channel
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [1:0]                        rsp_gesture_state,
   output logic                              rsp_state_changed,
   output logic [psgd_pkg::COLOR_W-1:0]      rsp_led_color,
   output logic [psgd_pkg::PROX_W-1:0]       rsp_led_brightness,
   // Configuration write channel
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [psgd_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [psgd_pkg::CSR_DAT_W-1:0]    csr_wdata
);

   import psgd_pkg::*;

   // Configuration registers.
   logic [PROX_W-1:0] presence_threshold_ff;
   logic [HOLD_W-1:0] settle_time_ms_ff;
   logic [PROX_W-1:0] swipe_delta_ff;
   logic [HOLD_W-1:0] swipe_hold_ms_ff;
   logic [PROX_W-1:0] brightness_scale_ff;

   // Input register.
   logic              in_valid_ff;
   logic [PROX_W-1:0] in_prox_ff;
   logic [TIME_W-1:0] in_now_ff;

   // Detector state.
   gesture_state_type mode_ff, mode_in;
   logic [TIME_W-1:0] entry_time_ff, entry_time_in;
   logic [PROX_W-1:0] ring_ff [RING_DEPTH];
   logic [PTR_W-1:0]  ptr_ff, ptr_in;

   // Response register.
   logic               out_valid_ff;
   logic [1:0]         out_state_ff;
   logic               out_changed_ff;
   logic [COLOR_W-1:0] out_color_ff;
   logic [PROX_W-1:0]  out_bright_ff;

   // Datapath signals.
   logic                  out_free;
   logic                  advance;
   logic                  present;
   logic [PROX_W-1:0]     oldest;
   logic [PROX_W:0]       oldest_plus;
   logic [PROX_W:0]       newest_plus;
   logic [TIME_W-1:0]     elapsed;
   logic                  settled;
   logic                  hold_done;
   logic [2*PROX_W-1:0]   product;

   // Handshake control: the input register drains whenever the response slot frees.
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign csr_ready = 1'b1;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         presence_threshold_ff <= RST_PRESENCE_THRESHOLD;
         settle_time_ms_ff     <= RST_SETTLE_TIME_MS;
         swipe_delta_ff        <= RST_SWIPE_DELTA;
         swipe_hold_ms_ff      <= RST_SWIPE_HOLD_MS;
         brightness_scale_ff   <= RST_BRIGHTNESS_SCALE;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_PRESENCE_THRESHOLD: presence_threshold_ff <= csr_wdata[PROX_W-1:0];
            CSR_SETTLE_TIME_MS:     settle_time_ms_ff     <= csr_wdata[HOLD_W-1:0];
            CSR_SWIPE_DELTA:        swipe_delta_ff        <= csr_wdata[PROX_W-1:0];
            CSR_SWIPE_HOLD_MS:      swipe_hold_ms_ff      <= csr_wdata[HOLD_W-1:0];
            CSR_BRIGHTNESS_SCALE:   brightness_scale_ff   <= csr_wdata[PROX_W-1:0];
            default: ;
         endcase
      end
   end

   // Input register captures a beat whenever it is empty or draining.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         in_prox_ff <= req_proximity;
         in_now_ff  <= req_now_ms;
      end
   end

   // Ring pointer advance; the oldest sample is the entry after the one being written.
   assign ptr_in = (ptr_ff == PTR_W'(RING_DEPTH - 1)) ? '0 : ptr_ff + PTR_W'(1);
   assign oldest = ring_ff[ptr_in];

   // Comparisons for presence, elapsed time and swipe direction.
   assign present     = in_prox_ff > presence_threshold_ff;
   assign elapsed     = in_now_ff - entry_time_ff;
   assign settled     = elapsed >= {{(TIME_W-HOLD_W){1'b0}}, settle_time_ms_ff};
   assign hold_done   = elapsed >= {{(TIME_W-HOLD_W){1'b0}}, swipe_hold_ms_ff};
   assign oldest_plus = {1'b0, oldest} + {1'b0, swipe_delta_ff};
   assign newest_plus = {1'b0, in_prox_ff} + {1'b0, swipe_delta_ff};
   assign product     = {{PROX_W{1'b0}}, in_prox_ff} * {{PROX_W{1'b0}}, brightness_scale_ff};

   // Next state and entry time.
   always_comb begin
      mode_in       = mode_ff;
      entry_time_in = entry_time_ff;
      unique case (mode_ff)
         ST_IDLE: begin
            if (present) begin
               mode_in       = ST_HAND;
               entry_time_in = in_now_ff;
            end
         end
         ST_HAND: begin
            if (!present) begin
               mode_in = ST_IDLE;
            end else if (settled) begin
               if ({1'b0, in_prox_ff} > oldest_plus) begin
                  mode_in       = ST_TOWARDS;
                  entry_time_in = in_now_ff;
               end else if (newest_plus < {1'b0, oldest}) begin
                  // A swipe away needs oldest - delta to stay non-negative.
                  mode_in       = ST_AWAY;
                  entry_time_in = in_now_ff;
               end
            end
         end
         ST_TOWARDS, ST_AWAY: begin
            if (!present) begin
               mode_in = ST_IDLE;
            end else if (hold_done) begin
               mode_in       = ST_HAND;
               entry_time_in = in_now_ff;
            end
         end
         default: mode_in = ST_IDLE;
      endcase
   end

   // State register, pointer and entry time step once per beat.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= ST_IDLE;
         entry_time_ff <= '0;
         ptr_ff        <= '0;
      end else if (advance) begin
         mode_ff       <= mode_in;
         entry_time_ff <= entry_time_in;
         ptr_ff        <= ptr_in;
      end
   end

   // Sample ring, cleared at reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < RING_DEPTH; i++) begin
            ring_ff[i] <= '0;
         end
      end else if (advance) begin
         ring_ff[ptr_ff] <= in_prox_ff;
      end
   end

   // Response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_state_ff   <= mode_in;
         out_changed_ff <= (mode_in != mode_ff);
         out_color_ff   <= color_of_state(mode_ff);
         out_bright_ff  <= product[2*PROX_W-1:PROX_W];
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_gesture_state  = out_state_ff;
   assign rsp_state_changed  = out_changed_ff;
   assign rsp_led_color      = out_color_ff;
   assign rsp_led_brightness = out_bright_ff;

   // The request side only stalls while a finished beat is held on the response side.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("request stalled without a held response");

   // Detector state moves only when a beat passes into the response register.
   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> ($stable(mode_ff) && $stable(ptr_ff) && $stable(entry_time_ff)))
      else $error("detector state changed without a beat");

   // A swipe is only entered from hand present, so its color must be the hand color.
   a_swipe_origin: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_state_changed &&
       (rsp_gesture_state == ST_TOWARDS || rsp_gesture_state == ST_AWAY))
      |-> (rsp_led_color == COLOR_HAND))
      else $error("swipe entered from a state other than hand present");

   // A response beat always reports the state the detector now holds.
   a_state_report: assert property (@(posedge clock) disable iff (reset)
      advance |=> (rsp_valid && rsp_gesture_state == mode_ff))
      else $error("response state differs from detector state");

endmodule
